/* rtl/mpoc_pkg.sv */
// Shared constants for the multi-pattern occurrence counter.
package mpoc_pkg;

    // Field widths of the input and result transactions
    localparam int MODE_W = 2;
    localparam int IDX_W  = 4;
    localparam int OFF_W  = 6;
    localparam int BYTE_W = 8;
    localparam int MASK_W = 16;
    localparam int CNT_W  = 32;

    // Default sizing
    localparam int DEF_NUM_PATTERNS = 16;
    localparam int DEF_MAX_LEN      = 64;

    // Transaction modes
    localparam logic [MODE_W-1:0] MODE_LOAD = 2'd0;
    localparam logic [MODE_W-1:0] MODE_TEXT = 2'd1;
    localparam logic [MODE_W-1:0] MODE_READ = 2'd2;

    // Saturation limit of an occurrence count
    localparam logic [CNT_W-1:0] TALLY_MAX = '1;

endpackage

/* rtl/mpoc_text_hist.sv */
// Circular text history: newest byte at age 0, registered read by age.
module mpoc_text_hist
    import mpoc_pkg::*;
#(
    parameter int MAX_LEN = DEF_MAX_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [BYTE_W-1:0]          i_push_byte,
    input  logic [$clog2(MAX_LEN)-1:0] i_rd_age,
    output logic [BYTE_W-1:0]          o_rd_byte
);

    localparam int AW = $clog2(MAX_LEN);
    localparam int HD = 1 << AW;

    logic [BYTE_W-1:0] r_mem [HD];
    logic [HD-1:0]     r_vld;
    logic [AW-1:0]     r_wp;
    logic [AW-1:0]     n_wp;
    logic [AW-1:0]     rd_addr;
    logic [BYTE_W-1:0] r_rd;

    assign n_wp    = r_wp + AW'(1);
    assign rd_addr = r_wp - i_rd_age;

    // Pointer and valid bits: entries never written read as zero bytes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_vld <= '0;
        end else if (i_push) begin
            r_wp        <= n_wp;
            r_vld[n_wp] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[n_wp] <= i_push_byte;
        end
        r_rd <= r_vld[rd_addr] ? r_mem[rd_addr] : '0;
    end

    assign o_rd_byte = r_rd;

endmodule

/* rtl/multi_pattern_occurrence_counter.sv */
// Top level: multi-pattern occurrence counter with a shared byte-compare sequencer.
//
//  channel | direction | handshake                    | payload
//  --------+-----------+------------------------------+-------------------------------------
//  in      | to block  | i_in_valid / o_in_ready      | i_mode, i_pattern_index,
//          |           |                              | i_char_offset, i_data_byte, i_last_char
//  out     | from block| o_out_valid / i_out_ready    | o_match_mask, o_occurrence_count
//
// Steps: a load goes to the output state and a count read via S_RDCNT; a text byte visits
// each slot: an inactive one is skipped, a match advances it, and a mismatch or full
// match runs the naive fallback rescan, up to about MAX_LEN^2/2 compares per slot.
// All slots share two byte comparators, one pattern read port and one history read port.
// Reset: synchronous, active low; clears the slot valid bits and the history valid bits
// at once, so no clearing pass is needed. The pattern store is not cleared.
// Stalls: input is taken only when the sequencer is idle; a finished result waits in
// the output register, and a later result holds until that register is free.
module multi_pattern_occurrence_counter
    import mpoc_pkg::*;
#(
    parameter int NUM_PATTERNS = DEF_NUM_PATTERNS,
    parameter int MAX_LEN      = DEF_MAX_LEN
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [MODE_W-1:0] i_mode,
    input  logic [IDX_W-1:0]  i_pattern_index,
    input  logic [OFF_W-1:0]  i_char_offset,
    input  logic [BYTE_W-1:0] i_data_byte,
    input  logic              i_last_char,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [MASK_W-1:0] o_match_mask,
    output logic [CNT_W-1:0]  o_occurrence_count
);

    // Widths: LW indexes a pattern byte, LENW holds a length, PW indexes a slot
    localparam int LW        = $clog2(MAX_LEN);
    localparam int LENW      = $clog2(MAX_LEN + 1);
    localparam int PW        = (NUM_PATTERNS > 1) ? $clog2(NUM_PATTERNS) : 1;
    localparam int PAT_DEPTH = NUM_PATTERNS << LW;

    // Sequencer states
    localparam logic [2:0] S_IDLE     = 3'd0;
    localparam logic [2:0] S_RDCNT    = 3'd1;
    localparam logic [2:0] S_SLOT_CHK = 3'd2;
    localparam logic [2:0] S_STEP     = 3'd3;
    localparam logic [2:0] S_FB       = 3'd4;
    localparam logic [2:0] S_OUT      = 3'd5;

    typedef struct packed {
        logic [LENW-1:0]  len;
        logic [LW-1:0]    pos;
        logic [CNT_W-1:0] tally;
    } t_slot_ent;

    // Memories and their registered read data
    logic [BYTE_W-1:0]      r_pat_mem  [PAT_DEPTH];
    t_slot_ent              r_slot_mem [NUM_PATTERNS];
    logic [NUM_PATTERNS-1:0] r_slot_vld;
    logic [BYTE_W-1:0]      r_pat_rd;
    t_slot_ent              r_slot_rd;
    logic                   r_slot_rd_vld;
    logic [BYTE_W-1:0]      hist_rd;

    // Sequencer registers
    logic [2:0]        r_state, n_state;
    logic [PW-1:0]     r_p, n_p;
    logic [BYTE_W-1:0] r_byte, n_byte;
    logic [LW-1:0]     r_cand, n_cand;
    logic [LW-1:0]     r_j, n_j;
    logic              r_hit, n_hit;
    logic              r_rd_ok, n_rd_ok;
    logic [MASK_W-1:0] r_mask, n_mask;
    logic [CNT_W-1:0]  r_cnt, n_cnt;
    logic              r_out_vld, n_out_vld;
    logic [MASK_W-1:0] r_out_mask, n_out_mask;
    logic [CNT_W-1:0]  r_out_cnt, n_out_cnt;

    // Memory port controls
    logic                 in_acc;
    logic                 pat_we, pat_re;
    logic [PW+LW-1:0]     pat_waddr, pat_raddr;
    logic                 slot_we, slot_re;
    logic [PW-1:0]        slot_waddr, slot_raddr;
    t_slot_ent            slot_wdata;
    logic                 hist_push;
    logic [LW-1:0]        hist_age;

    // Shared compare unit and per-slot helpers
    logic                 step_eq, fb_eq, hit_now;
    logic [LENW-1:0]      step_k;
    logic                 do_wr, nxt_slot;
    logic [LW-1:0]        wr_pos;
    logic [CNT_W-1:0]     wr_tally;

    assign in_acc     = i_in_valid && o_in_ready;
    assign o_in_ready = (r_state == S_IDLE);

    assign step_eq = (r_pat_rd == r_byte);
    assign fb_eq   = (hist_rd == r_pat_rd);
    assign step_k  = LENW'(r_slot_rd.pos) + LENW'(1);
    assign hit_now = (r_state == S_STEP) ? (step_eq && (step_k >= r_slot_rd.len)) : r_hit;

    // Saturating tally bump on a full match
    always_comb begin
        wr_tally = r_slot_rd.tally;
        if (hit_now && (r_slot_rd.tally != TALLY_MAX)) begin
            wr_tally = r_slot_rd.tally + CNT_W'(1);
        end
    end

    mpoc_text_hist #(
        .MAX_LEN (MAX_LEN)
    ) u_hist (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (hist_push),
        .i_push_byte (i_data_byte),
        .i_rd_age    (hist_age),
        .o_rd_byte   (hist_rd)
    );

    always_comb begin
        n_state    = r_state;
        n_p        = r_p;
        n_byte     = r_byte;
        n_cand     = r_cand;
        n_j        = r_j;
        n_hit      = r_hit;
        n_rd_ok    = r_rd_ok;
        n_mask     = r_mask;
        n_cnt      = r_cnt;
        n_out_vld  = r_out_vld;
        n_out_mask = r_out_mask;
        n_out_cnt  = r_out_cnt;

        pat_we     = 1'b0;
        pat_waddr  = {PW'(i_pattern_index), LW'(i_char_offset)};
        pat_re     = 1'b0;
        pat_raddr  = {r_p, LW'(0)};
        slot_we    = 1'b0;
        slot_waddr = r_p;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = r_p;
        hist_push  = 1'b0;
        hist_age   = '0;
        do_wr      = 1'b0;
        nxt_slot   = 1'b0;
        wr_pos     = '0;

        // Free the output register once the result is taken
        if (r_out_vld && i_out_ready) begin
            n_out_vld = 1'b0;
        end

        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    n_mask = '0;
                    n_cnt  = '0;
                    n_byte = i_data_byte;
                    n_state = S_OUT;
                    case (i_mode)
                        MODE_LOAD: begin
                            if ((32'(i_pattern_index) < NUM_PATTERNS)
                                && (32'(i_char_offset) < MAX_LEN)) begin
                                pat_we = 1'b1;
                                if (i_last_char) begin
                                    slot_we         = 1'b1;
                                    slot_waddr      = PW'(i_pattern_index);
                                    slot_wdata.len  = LENW'(i_char_offset) + LENW'(1);
                                    slot_wdata.pos  = '0;
                                    slot_wdata.tally = '0;
                                end
                            end
                        end
                        MODE_TEXT: begin
                            // Push the byte, then visit every slot from the first
                            hist_push  = 1'b1;
                            n_p        = '0;
                            slot_re    = 1'b1;
                            slot_raddr = '0;
                            n_state    = S_SLOT_CHK;
                        end
                        MODE_READ: begin
                            n_rd_ok    = (32'(i_pattern_index) < NUM_PATTERNS);
                            slot_re    = 1'b1;
                            slot_raddr = PW'(i_pattern_index);
                            n_state    = S_RDCNT;
                        end
                        default: begin
                            n_state = S_OUT;
                        end
                    endcase
                end
            end

            S_RDCNT: begin
                n_cnt   = (r_rd_ok && r_slot_rd_vld) ? r_slot_rd.tally : '0;
                n_state = S_OUT;
            end

            S_SLOT_CHK: begin
                // Skip inactive slots; otherwise fetch the byte at the match position
                if (r_slot_rd_vld && (r_slot_rd.len != '0)) begin
                    pat_re    = 1'b1;
                    pat_raddr = {r_p, r_slot_rd.pos};
                    n_state   = S_STEP;
                end else begin
                    nxt_slot = 1'b1;
                end
            end

            S_STEP: begin
                n_hit = step_eq;
                if (step_eq && (step_k < r_slot_rd.len)) begin
                    do_wr    = 1'b1;
                    wr_pos   = LW'(step_k);
                    nxt_slot = 1'b1;
                end else begin
                    if (step_eq) begin
                        for (int i = 0; i < MASK_W; i++) begin
                            if (32'(r_p) == i) begin
                                n_mask[i] = 1'b1;
                            end
                        end
                    end
                    // First fallback candidate is one shorter than the advanced position
                    if (r_slot_rd.pos == '0) begin
                        do_wr    = 1'b1;
                        wr_pos   = '0;
                        nxt_slot = 1'b1;
                    end else begin
                        n_cand    = r_slot_rd.pos;
                        n_j       = '0;
                        pat_re    = 1'b1;
                        pat_raddr = {r_p, LW'(0)};
                        hist_age  = r_slot_rd.pos - LW'(1);
                        n_state   = S_FB;
                    end
                end
            end

            S_FB: begin
                // One byte compare a cycle: history[cand-1-j] against pattern[j]
                if (fb_eq) begin
                    if ((r_j + LW'(1)) == r_cand) begin
                        do_wr    = 1'b1;
                        wr_pos   = r_cand;
                        nxt_slot = 1'b1;
                    end else begin
                        n_j       = r_j + LW'(1);
                        pat_re    = 1'b1;
                        pat_raddr = {r_p, r_j + LW'(1)};
                        hist_age  = r_cand - r_j - LW'(2);
                    end
                end else begin
                    if (r_cand == LW'(1)) begin
                        do_wr    = 1'b1;
                        wr_pos   = '0;
                        nxt_slot = 1'b1;
                    end else begin
                        n_cand    = r_cand - LW'(1);
                        n_j       = '0;
                        pat_re    = 1'b1;
                        pat_raddr = {r_p, LW'(0)};
                        hist_age  = r_cand - LW'(2);
                    end
                end
            end

            S_OUT: begin
                // Hold the result until the output register is free
                if (!r_out_vld || i_out_ready) begin
                    n_out_vld  = 1'b1;
                    n_out_mask = r_mask;
                    n_out_cnt  = r_cnt;
                    n_state    = S_IDLE;
                end
            end

            default: begin
                n_state = S_IDLE;
            end
        endcase

        // Write back the slot just finished
        if (do_wr) begin
            slot_we          = 1'b1;
            slot_waddr       = r_p;
            slot_wdata.len   = r_slot_rd.len;
            slot_wdata.pos   = wr_pos;
            slot_wdata.tally = wr_tally;
        end

        // Advance to the next slot, or finish after the last one
        if (nxt_slot) begin
            if (r_p == PW'(NUM_PATTERNS - 1)) begin
                n_state = S_OUT;
            end else begin
                n_p        = r_p + PW'(1);
                slot_re    = 1'b1;
                slot_raddr = r_p + PW'(1);
                n_state    = S_SLOT_CHK;
            end
        end
    end

    // Control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_out_vld  <= 1'b0;
            r_slot_vld <= '0;
        end else begin
            r_state   <= n_state;
            r_out_vld <= n_out_vld;
            if (slot_we) begin
                r_slot_vld[slot_waddr] <= 1'b1;
            end
        end
    end

    // Working and result payload
    always_ff @(posedge i_clk) begin
        r_p        <= n_p;
        r_byte     <= n_byte;
        r_cand     <= n_cand;
        r_j        <= n_j;
        r_hit      <= n_hit;
        r_rd_ok    <= n_rd_ok;
        r_mask     <= n_mask;
        r_cnt      <= n_cnt;
        r_out_mask <= n_out_mask;
        r_out_cnt  <= n_out_cnt;
    end

    // Pattern store: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (pat_we) begin
            r_pat_mem[pat_waddr] <= i_data_byte;
        end
        if (pat_re) begin
            r_pat_rd <= r_pat_mem[pat_raddr];
        end
    end

    // Slot table: one write, one registered read
    always_ff @(posedge i_clk) begin
        if (slot_we) begin
            r_slot_mem[slot_waddr] <= slot_wdata;
        end
        if (slot_re) begin
            r_slot_rd     <= r_slot_mem[slot_raddr];
            r_slot_rd_vld <= r_slot_vld[slot_raddr];
        end
    end

    assign o_out_valid        = r_out_vld;
    assign o_match_mask       = r_out_mask;
    assign o_occurrence_count = r_out_cnt;

endmodule

/* test/multi_pattern_occurrence_counter_tb.sv */
// Self-checking testbench for the multi-pattern occurrence counter.
module multi_pattern_occurrence_counter_tb;
    import mpoc_pkg::*;

    // Sizing mirrors the block defaults; the predictor arrays follow it
    localparam int PTN_SLOTS   = DEF_NUM_PATTERNS;
    localparam int PTN_MAX_LEN = DEF_MAX_LEN;
    localparam int PTN_LEN_W   = 7;

    // Mode 3 does nothing in the block but still returns an all-zero result
    localparam logic [MODE_W-1:0] MODE_NOP = 2'd3;

    localparam int    ITEM_TARGET    = 1400;
    localparam int    SETTLE_CYCLES  = 20;
    // Time limit for the whole run, far above the slowest realistic run
    localparam longint RUN_LIMIT     = 64'd60_000_000;

    typedef struct packed {
        logic [MASK_W-1:0] mask;
        logic [CNT_W-1:0]  count;
    } t_scan_result;

    logic              i_clk              = 1'b0;
    logic              i_rst_n            = 1'b0;
    logic              i_in_valid         = 1'b0;
    logic              o_in_ready;
    logic [MODE_W-1:0] i_mode             = '0;
    logic [IDX_W-1:0]  i_pattern_index    = '0;
    logic [OFF_W-1:0]  i_char_offset      = '0;
    logic [BYTE_W-1:0] i_data_byte        = '0;
    logic              i_last_char        = 1'b0;
    logic              o_out_valid;
    logic              i_out_ready        = 1'b0;
    logic [MASK_W-1:0] o_match_mask;
    logic [CNT_W-1:0]  o_occurrence_count;

    // Predictor state: pattern bytes, lengths, match positions, tallies, text history
    logic [BYTE_W-1:0]      ptn_bytes   [PTN_SLOTS][PTN_MAX_LEN];
    logic [PTN_MAX_LEN-1:0] ptn_written [PTN_SLOTS] = '{default: '0};
    logic [PTN_LEN_W-1:0]   ptn_len     [PTN_SLOTS] = '{default: '0};
    logic [OFF_W-1:0]       ptn_pos     [PTN_SLOTS] = '{default: '0};
    logic [CNT_W-1:0]       ptn_tally   [PTN_SLOTS] = '{default: '0};
    logic [BYTE_W-1:0]      text_hist   [PTN_MAX_LEN] = '{default: '0};

    t_scan_result results_due [$];
    int           fault_count = 0;
    int           items_sent  = 0;
    bit           steady_run  = 1'b0;

    multi_pattern_occurrence_counter #(
        .NUM_PATTERNS (PTN_SLOTS),
        .MAX_LEN      (PTN_MAX_LEN)
    ) dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_in_valid         (i_in_valid),
        .o_in_ready         (o_in_ready),
        .i_mode             (i_mode),
        .i_pattern_index    (i_pattern_index),
        .i_char_offset      (i_char_offset),
        .i_data_byte        (i_data_byte),
        .i_last_char        (i_last_char),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (i_out_ready),
        .o_match_mask       (o_match_mask),
        .o_occurrence_count (o_occurrence_count)
    );

    // 12-unit period: high for six, low for six
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Result side back-pressure: drop ready at random about 15 percent of the time,
    // never during the steady stretch
    always @(negedge i_clk) begin
        i_out_ready <= steady_run || ($urandom_range(0, 99) >= 15);
    end

    // Print one line per mismatch and count it
    task automatic report_mismatch(input string what, input logic [CNT_W-1:0] got,
                                   input logic [CNT_W-1:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        fault_count++;
    endtask

    // Longest proper border: the longest length below limit for which the newest
    // text bytes spell the start of the pattern; zero when there is none
    function automatic int longest_border(input int slot, input int limit);
        int cand;
        bit hit;
        for (int n = limit; n > 1; n--) begin
            cand = n - 1;
            hit  = 1'b1;
            for (int j = 0; j < cand; j++) begin
                if (text_hist[cand - 1 - j] != ptn_bytes[slot][j]) begin
                    hit = 1'b0;
                    break;
                end
            end
            if (hit)
                return cand;
        end
        return 0;
    endfunction

    // Apply one accepted transaction to the predictor and queue the result it owes
    task automatic predict_occurrences(input logic [MODE_W-1:0] mode,
                                       input logic [IDX_W-1:0] idx,
                                       input logic [OFF_W-1:0] off,
                                       input logic [BYTE_W-1:0] data,
                                       input logic last);
        t_scan_result res;
        int           k;
        res = '0;
        case (mode)
            MODE_LOAD: begin
                ptn_bytes[idx][off]   = data;
                ptn_written[idx][off] = 1'b1;
                // Final byte fixes the length and restarts the slot from scratch
                if (last) begin
                    ptn_len[idx]   = PTN_LEN_W'(off) + 1'b1;
                    ptn_pos[idx]   = '0;
                    ptn_tally[idx] = '0;
                end
            end
            MODE_TEXT: begin
                for (int h = PTN_MAX_LEN - 1; h > 0; h--)
                    text_hist[h] = text_hist[h - 1];
                text_hist[0] = data;
                for (int p = 0; p < PTN_SLOTS; p++) begin
                    if (ptn_len[p] != 0) begin
                        k = int'(ptn_pos[p]) + 1;
                        if (data == ptn_bytes[p][ptn_pos[p]]) begin
                            if (k >= int'(ptn_len[p])) begin
                                // Full match: count (saturating), flag, fall back
                                if (ptn_tally[p] != TALLY_MAX)
                                    ptn_tally[p] = ptn_tally[p] + 1'b1;
                                res.mask[p] = 1'b1;
                                ptn_pos[p]  = OFF_W'(longest_border(p, k));
                            end else begin
                                ptn_pos[p] = OFF_W'(k);
                            end
                        end else begin
                            ptn_pos[p] = OFF_W'(longest_border(p, k));
                        end
                    end
                end
            end
            MODE_READ: res.count = ptn_tally[idx];
            default: ;
        endcase
        results_due.push_back(res);
    endtask

    // Offer one transaction on the input channel and hold it until it is taken.
    // Every change happens at a falling edge; acceptance is judged at the rising one.
    task automatic send_item(input logic [MODE_W-1:0] mode, input logic [IDX_W-1:0] idx,
                             input logic [OFF_W-1:0] off, input logic [BYTE_W-1:0] data,
                             input logic last);
        @(negedge i_clk);
        // Random source gaps, suppressed during the steady stretch
        if (!steady_run) begin
            while ($urandom_range(0, 99) < 15) begin
                i_in_valid <= 1'b0;
                @(negedge i_clk);
            end
        end
        i_in_valid      <= 1'b1;
        i_mode          <= mode;
        i_pattern_index <= idx;
        i_char_offset   <= off;
        i_data_byte     <= data;
        i_last_char     <= last;
        @(posedge i_clk);
        while (!o_in_ready)
            @(posedge i_clk);
        predict_occurrences(mode, idx, off, data, last);
        items_sent++;
    endtask

    task automatic send_text(input logic [BYTE_W-1:0] data);
        send_item(MODE_TEXT, IDX_W'($urandom), OFF_W'($urandom), data, 1'($urandom));
    endtask

    task automatic send_read(input int slot);
        send_item(MODE_READ, IDX_W'(slot), OFF_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
    endtask

    // Load a whole pattern; the body bytes go in forwards or backwards, and the
    // final byte always goes last so no unwritten byte ever becomes live
    task automatic load_pattern(input int slot, input logic [BYTE_W-1:0] body [$]);
        int last_off;
        last_off = body.size() - 1;
        if (last_off > 0 && $urandom_range(0, 1) == 1) begin
            for (int o = last_off - 1; o >= 0; o--)
                send_item(MODE_LOAD, IDX_W'(slot), OFF_W'(o), body[o], 1'b0);
        end else begin
            for (int o = 0; o < last_off; o++)
                send_item(MODE_LOAD, IDX_W'(slot), OFF_W'(o), body[o], 1'b0);
        end
        send_item(MODE_LOAD, IDX_W'(slot), OFF_W'(last_off), body[last_off], 1'b1);
    endtask

    // Counts read zero after reset, on the lowest and highest slot; mode 3 is inert
    task automatic test_idle_reads();
        send_read(0);
        send_read(PTN_SLOTS - 1);
        send_item(MODE_NOP, IDX_W'($urandom), OFF_W'($urandom), BYTE_W'($urandom),
                  1'($urandom));
    endtask

    // Text with no active slot, then zero bytes and 0xFF as ordinary pattern bytes
    task automatic test_zero_bytes();
        send_text(8'h00);
        load_pattern(PTN_SLOTS - 1, {8'h00, 8'h00});
        load_pattern(0, {8'hFF});
        send_text(8'h00);
        send_text(8'h00);
        send_text(8'h00);
        send_text(8'hFF);
    endtask

    // Overlapping prefix: a mismatch must fall back to a partial match, not zero
    task automatic test_overlap_fallback();
        load_pattern(1, {8'h61, 8'h61, 8'h62});
        send_text(8'h61);
        send_text(8'h61);
        send_text(8'h61);
        send_text(8'h62);
    endtask

    // Reload mid-stream with a shorter length: count and position restart
    task automatic test_reload_clears();
        send_item(MODE_LOAD, IDX_W'(1), OFF_W'(1), 8'h61, 1'b1);
        send_text(8'h61);
        send_text(8'h61);
        send_text(8'h61);
        send_read(1);
        send_read(PTN_SLOTS - 1);
    endtask

    // Phases of well-formed work: load a set of patterns over a small alphabet,
    // then stream text from that alphabet, sprinkled with reads, stray loads,
    // inert transactions and off-alphabet bytes
    task automatic test_random_stream();
        logic [BYTE_W-1:0] alphabet [3];
        logic [BYTE_W-1:0] body [$];
        int                n_alpha;
        int                n_load;
        int                n_text;
        int                slot;
        int                len;
        int                roll;
        int                prefix;
        int                off;
        int                phase;
        phase = 0;
        while (items_sent < ITEM_TARGET) begin
            // One phase runs with neither side idling
            steady_run = (phase == 3);
            n_alpha = $urandom_range(2, 3);
            for (int a = 0; a < 3; a++)
                alphabet[a] = BYTE_W'($urandom);
            // Keep the first phase sparse so inactive slots stay in play
            n_load = (phase == 0) ? $urandom_range(1, 4) : $urandom_range(1, PTN_SLOTS);
            for (int s = 0; s < n_load; s++) begin
                slot = $urandom_range(0, PTN_SLOTS - 1);
                roll = $urandom_range(0, 99);
                if (phase == 2 && s == 0)
                    len = PTN_MAX_LEN;
                else if (roll < 80)
                    len = $urandom_range(1, 6);
                else if (roll < 95)
                    len = $urandom_range(7, 20);
                else
                    len = $urandom_range(21, PTN_MAX_LEN);
                body.delete();
                for (int b = 0; b < len; b++)
                    body.push_back(alphabet[$urandom_range(0, n_alpha - 1)]);
                load_pattern(slot, body);
            end
            n_text = $urandom_range(80, 160);
            for (int t = 0; t < n_text; t++) begin
                roll = $urandom_range(0, 99);
                if (roll < 8) begin
                    send_read($urandom_range(0, PTN_SLOTS - 1));
                end else if (roll < 11) begin
                    // Stray load: any byte anywhere; may end the pattern only where
                    // every lower offset already holds a byte
                    slot   = $urandom_range(0, PTN_SLOTS - 1);
                    off    = $urandom_range(0, PTN_MAX_LEN - 1);
                    prefix = 0;
                    while (prefix < PTN_MAX_LEN && ptn_written[slot][prefix])
                        prefix++;
                    send_item(MODE_LOAD, IDX_W'(slot), OFF_W'(off), BYTE_W'($urandom),
                              (off <= prefix) ? 1'($urandom) : 1'b0);
                end else if (roll < 13) begin
                    send_item(MODE_NOP, IDX_W'($urandom), OFF_W'($urandom),
                              BYTE_W'($urandom), 1'($urandom));
                end else if (roll < 28) begin
                    send_text(BYTE_W'($urandom));
                end else begin
                    send_text(alphabet[$urandom_range(0, n_alpha - 1)]);
                end
            end
            phase++;
        end
        steady_run = 1'b0;
    endtask

    // Compare every taken result with the oldest one owed, field by field
    always @(posedge i_clk) begin : result_check
        t_scan_result due;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (results_due.size() == 0) begin
                report_mismatch("result with nothing owed, mask", CNT_W'(o_match_mask), '0);
            end else begin
                due = results_due.pop_front();
                if (o_match_mask !== due.mask)
                    report_mismatch("match_mask", CNT_W'(o_match_mask), CNT_W'(due.mask));
                if (o_occurrence_count !== due.count)
                    report_mismatch("occurrence_count", o_occurrence_count, due.count);
            end
        end
    end

    initial begin
        // Hold reset from time zero, then release it at a falling edge
        repeat (10) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_idle_reads();
        test_zero_bytes();
        test_overlap_fallback();
        test_reload_clears();
        test_random_stream();

        // Drop valid, wait for every owed result, then let the block settle
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
        if (fault_count == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

    // Watchdog: a hung handshake ends the run as a failure
    initial begin
        #(RUN_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
    end

endmodule

/* files.f */
rtl/mpoc_pkg.sv
rtl/mpoc_text_hist.sv
rtl/multi_pattern_occurrence_counter.sv
test/multi_pattern_occurrence_counter_tb.sv
